// File: hw/rtl/q2e_pkg.sv
package q2e_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int COMP_WIDTH_DEF    = 16;
	localparam int ATAN_LEN          = 24;
	localparam int DW                = 42;
	localparam int SQ_BITS           = 29;
	localparam int NW                = 57;
	localparam int THR_W             = 15;
	localparam int AW                = 16;
	localparam logic [THR_W-1:0] THR_RESET = 15'd16382;

	typedef struct packed {
		logic                    locked;
		logic signed [AW-1:0]    s14;
		logic signed [DW-1:0]    hy;
		logic signed [DW-1:0]    hx;
		logic signed [DW-1:0]    py;
		logic signed [DW-1:0]    by;
		logic signed [DW-1:0]    bx;
	} carry_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic [31:0]          z;
		logic                 zero;
	} vec_t;

	typedef struct packed {
		vec_t                 hd;
		vec_t                 pt;
		vec_t                 bk;
		logic                 locked;
		logic signed [AW-1:0] s14;
	} rot_t;

	function automatic logic [31:0] atan_entry(input int i);
		logic [31:0] r;
		unique case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// fold a left half-plane vector over before the rotations
	function automatic vec_t vec_prep(input logic signed [DW-1:0] y,
			input logic signed [DW-1:0] x);
		vec_t v;
		v.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			v.x = -x;
			v.y = -y;
			v.z = 32'h8000_0000;
		end else begin
			v.x = x;
			v.y = y;
			v.z = 32'h0;
		end
		return v;
	endfunction

	function automatic logic [AW-1:0] vec_angle(input vec_t v);
		logic [31:0] r;
		r = v.z + 32'h0000_8000;
		return v.zero ? '0 : r[31:16];
	endfunction

endpackage

// File: hw/rtl/q2e_cfg_if.sv
interface q2e_cfg_if;
	import q2e_pkg::*;
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] lock_threshold;
	modport source(output valid, output lock_threshold, input ready);
	modport sink(input valid, input lock_threshold, output ready);
endinterface

// File: hw/rtl/q2e_sample_if.sv
interface q2e_sample_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic signed [CW-1:0] quat_w;
	logic signed [CW-1:0] quat_x;
	logic signed [CW-1:0] quat_y;
	logic signed [CW-1:0] quat_z;
	modport source(output valid, output mode, output quat_w, output quat_x,
		output quat_y, output quat_z, input ready);
	modport sink(input valid, input mode, input quat_w, input quat_x,
		input quat_y, input quat_z, output ready);
endinterface

// File: hw/rtl/q2e_result_if.sv
interface q2e_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] heading_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] bank_angle;
	logic               gimbal_locked;
	modport source(output valid, output heading_angle, output pitch_angle,
		output bank_angle, output gimbal_locked, input ready);
	modport sink(input valid, input heading_angle, input pitch_angle,
		input bank_angle, input gimbal_locked, output ready);
endinterface

// File: hw/rtl/q2e_front.sv
module q2e_front
	import q2e_pkg::*;
#(
	parameter int CW = COMP_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_i,
	input  logic                 mode,
	input  logic signed [CW-1:0] quat_w,
	input  logic signed [CW-1:0] quat_x,
	input  logic signed [CW-1:0] quat_y,
	input  logic signed [CW-1:0] quat_z,
	input  logic [THR_W-1:0]     thr,
	output logic                 valid_o,
	output logic [NW-1:0]        n_o,
	output carry_t               carry_o
);
	localparam int EW = (CW > 18) ? CW : 18;
	localparam logic signed [EW-1:0] LIM = EW'(65536);
	localparam logic signed [DW-1:0] HALF = DW'(134217728);
	localparam logic signed [DW-1:0] ONE = DW'(268435456);

	function automatic logic signed [17:0] clamp(input logic signed [CW-1:0] raw);
		logic signed [EW-1:0] e;
		e = EW'(raw);
		if (e > LIM)
			return 18'sd65536;
		else if (e < -LIM)
			return -18'sd65536;
		return e[17:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic mode_s1, mode_s2;
	logic signed [17:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [35:0] wx_s2, yz_s2, wy_s2, xz_s2, xy_s2, wz_s2, xx_s2, yy_s2, zz_s2;
	logic signed [29:0] s28_s3;
	logic [28:0] mag_s3;
	logic signed [DW-1:0] hyl_s3, hxl_s3, hyu_s3, hxu_s3, by_s3, bx_s3;
	logic [27:0] a2_s4;
	logic [28:0] ab_s4;
	logic [29:0] b2_s4;
	carry_t c_s4, c_s5;
	logic [NW-1:0] n_s5;

	logic signed [DW-1:0] e_wx, e_yz, e_wy, e_xz, e_xy, e_wz, e_xx, e_yy, e_zz;
	logic signed [DW-1:0] t3, s3, sat3;
	logic [15:0] m14;
	logic [13:0] a4;
	logic [14:0] b4;
	logic [NW-1:0] sq5;

	always_comb begin
		e_wx = DW'(wx_s2);
		e_yz = DW'(yz_s2);
		e_wy = DW'(wy_s2);
		e_xz = DW'(xz_s2);
		e_xy = DW'(xy_s2);
		e_wz = DW'(wz_s2);
		e_xx = DW'(xx_s2);
		e_yy = DW'(yy_s2);
		e_zz = DW'(zz_s2);
		t3 = mode_s2 ? (e_yz + e_wx) : (e_yz - e_wx);
		s3 = -(t3 <<< 1);
		if (s3 > ONE)
			sat3 = ONE;
		else if (s3 < -ONE)
			sat3 = -ONE;
		else
			sat3 = s3;
		m14 = 16'((30'(mag_s3) + 30'd8192) >> 14);
		a4 = mag_s3[28:15];
		b4 = mag_s3[14:0];
		sq5 = (NW'(a2_s4) << 30) + (NW'(ab_s4) << 16) + NW'(b2_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			w_s1 <= clamp(quat_w);
			x_s1 <= clamp(quat_x);
			y_s1 <= clamp(quat_y);
			z_s1 <= clamp(quat_z);

			mode_s2 <= mode_s1;
			wx_s2 <= w_s1 * x_s1;
			yz_s2 <= y_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			xz_s2 <= x_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			wz_s2 <= w_s1 * z_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;

			s28_s3 <= sat3[29:0];
			mag_s3 <= sat3[DW-1] ? 29'(-sat3) : sat3[28:0];
			hyl_s3 <= mode_s2 ? (-e_xz - e_wy) : (-e_xz + e_wy);
			hxl_s3 <= HALF - e_yy - e_zz;
			hyu_s3 <= mode_s2 ? (e_xz - e_wy) : (e_xz + e_wy);
			hxu_s3 <= HALF - e_xx - e_yy;
			by_s3 <= mode_s2 ? (e_xy - e_wz) : (e_xy + e_wz);
			bx_s3 <= HALF - e_xx - e_zz;

			c_s4.locked <= m14 > {1'b0, thr};
			c_s4.s14 <= s28_s3[29] ? -$signed(m14) : $signed(m14);
			c_s4.hy <= (m14 > {1'b0, thr}) ? hyl_s3 : hyu_s3;
			c_s4.hx <= (m14 > {1'b0, thr}) ? hxl_s3 : hxu_s3;
			c_s4.py <= DW'(s28_s3);
			c_s4.by <= by_s3;
			c_s4.bx <= bx_s3;
			a2_s4 <= a4 * a4;
			ab_s4 <= a4 * b4;
			b2_s4 <= b4 * b4;

			c_s5 <= c_s4;
			n_s5 <= (NW'(1) << 56) - sq5;
		end
	end

	assign valid_o = v_s5;
	assign n_o = n_s5;
	assign carry_o = c_s5;

endmodule

// File: hw/rtl/q2e_sqrt_cell.sv
module q2e_sqrt_cell
	import q2e_pkg::*;
#(
	parameter int K = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_i,
	input  logic [NW-1:0]      rem_i,
	input  logic [SQ_BITS-1:0] root_i,
	input  carry_t             carry_i,
	output logic               valid_o,
	output logic [NW-1:0]      rem_o,
	output logic [SQ_BITS-1:0] root_o,
	output carry_t             carry_o
);
	logic [59:0] d;
	logic        take;

	always_comb begin
		d = (60'(root_i) << (K + 1)) + (60'(1) << (2 * K));
		take = 60'(rem_i) >= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_o <= 1'b0;
		else if (adv)
			valid_o <= valid_i;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_o <= take ? (rem_i - d[NW-1:0]) : rem_i;
			root_o <= take ? (root_i | (SQ_BITS'(1) << K)) : root_i;
			carry_o <= carry_i;
		end
	end

endmodule

// File: hw/rtl/q2e_cordic_cell.sv
module q2e_cordic_cell
	import q2e_pkg::*;
#(
	parameter int I = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_i,
	input  rot_t rot_i,
	output logic valid_o,
	output rot_t rot_o
);
	localparam logic [31:0] ATAN = atan_entry(I);

	function automatic vec_t step(input vec_t v);
		vec_t r;
		logic signed [DW-1:0] xs, ys;
		xs = v.x >>> I;
		ys = v.y >>> I;
		r.zero = v.zero;
		if (v.y >= 0) begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + ATAN;
		end else begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - ATAN;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_o <= 1'b0;
		else if (adv)
			valid_o <= valid_i;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rot_o.hd <= step(rot_i.hd);
			rot_o.pt <= step(rot_i.pt);
			rot_o.bk <= step(rot_i.bk);
			rot_o.locked <= rot_i.locked;
			rot_o.s14 <= rot_i.s14;
		end
	end

endmodule

// File: hw/rtl/quaternion_to_euler_unit.sv
// channel  | role   | carries
// cfg      | sink   | lock_threshold (Q1.14)
// sample   | sink   | mode, quat_w, quat_x, quat_y, quat_z
// result   | source | heading_angle, pitch_angle, bank_angle, gimbal_locked
//
// One sample per cycle while the result is not stalled; the path runs
// through five product stages, 29 square-root cells (one root bit each),
// the CORDIC cells and the output register.
// Reset clears every valid bit and loads lock_threshold with 16382.
// A stalled result freezes the whole row of cells; sample.ready follows it.
module quaternion_to_euler_unit
	import q2e_pkg::*;
#(
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
	parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	q2e_cfg_if.sink      cfg,
	q2e_sample_if.sink   sample,
	q2e_result_if.source result
);
	localparam int NC = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	logic             adv;
	logic [THR_W-1:0] thr_q;

	logic               sv   [SQ_BITS+1];
	logic [NW-1:0]      srem [SQ_BITS+1];
	logic [SQ_BITS-1:0] sroot[SQ_BITS+1];
	carry_t             scar [SQ_BITS+1];

	logic cv[NC+1];
	rot_t cr[NC+1];

	logic               out_valid_q;
	logic signed [15:0] heading_q, pitch_q, bank_q;
	logic               locked_q;

	assign adv = !out_valid_q || result.ready;
	assign sample.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (cfg.valid)
			thr_q <= cfg.lock_threshold;
	end

	q2e_front #(.CW(COMPONENT_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (sample.valid),
		.mode    (sample.mode),
		.quat_w  (sample.quat_w),
		.quat_x  (sample.quat_x),
		.quat_y  (sample.quat_y),
		.quat_z  (sample.quat_z),
		.thr     (thr_q),
		.valid_o (sv[0]),
		.n_o     (srem[0]),
		.carry_o (scar[0])
	);
	assign sroot[0] = '0;

	for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
		q2e_sqrt_cell #(.K(SQ_BITS - 1 - j)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (sv[j]),
			.rem_i   (srem[j]),
			.root_i  (sroot[j]),
			.carry_i (scar[j]),
			.valid_o (sv[j+1]),
			.rem_o   (srem[j+1]),
			.root_o  (sroot[j+1]),
			.carry_o (scar[j+1])
		);
	end

	always_comb begin
		cv[0] = sv[SQ_BITS];
		cr[0].hd = vec_prep(scar[SQ_BITS].hy, scar[SQ_BITS].hx);
		cr[0].pt = vec_prep(scar[SQ_BITS].py, DW'(sroot[SQ_BITS]));
		cr[0].bk = vec_prep(scar[SQ_BITS].by, scar[SQ_BITS].bx);
		cr[0].locked = scar[SQ_BITS].locked;
		cr[0].s14 = scar[SQ_BITS].s14;
	end

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		q2e_cordic_cell #(.I(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (cv[i]),
			.rot_i   (cr[i]),
			.valid_o (cv[i+1]),
			.rot_o   (cr[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= cv[NC];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_q <= vec_angle(cr[NC].hd);
			pitch_q <= cr[NC].locked ? cr[NC].s14 : vec_angle(cr[NC].pt);
			bank_q <= cr[NC].locked ? '0 : vec_angle(cr[NC].bk);
			locked_q <= cr[NC].locked;
		end
	end

	assign result.valid = out_valid_q;
	assign result.heading_angle = heading_q;
	assign result.pitch_angle = pitch_q;
	assign result.bank_angle = bank_q;
	assign result.gimbal_locked = locked_q;

`ifndef NO_ASSERTIONS
	a_bank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.gimbal_locked |-> result.bank_angle == 16'sd0)
		else $error("bank not zero under lock");
	a_lock_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.gimbal_locked |-> result.pitch_angle != 16'sd0)
		else $error("zero pitch under lock");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready == (!result.valid || result.ready))
		else $error("sample ready out of step with result stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cv[NC]) && $stable(sv[SQ_BITS]))
		else $error("cell row moved during stall");
`endif

endmodule
